// ----- hdl/pwls_pkg.sv -----
// shared types and constants for the priority wait list select block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pwls_pkg;

    localparam int LIST_DEPTH    = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int TAG_W      = 8;
    localparam int FIELD_PR_W = 8;
    localparam int OCC_W      = 5;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = (PRIORITY_BITS > FIELD_PR_W) ? PRIORITY_BITS : FIELD_PR_W;
    localparam int OCC_EXT_W  = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USED_W = 1 + TAG_W + FIELD_PR_W + 1 + OCC_W;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic             le;
        logic [CMP_W-1:0] bound;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_RESULT
    } state_t;

endpackage

// ----- hdl/pwls_list_mem.sv -----
// wait list storage: one write port, one read port with registered read data
// depends on pwls_pkg
`timescale 1ns / 1ps

module pwls_list_mem
    import pwls_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [LIST_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/pwls_cmp_unit.sv -----
// shared compare unit: one entry priority against the running bound per cycle
// depends on pwls_pkg
`timescale 1ns / 1ps

module pwls_cmp_unit
    import pwls_pkg::*;
(
    input  logic [PRIORITY_BITS-1:0] data_prio,
    input  logic [CMP_W-1:0]         bound,
    input  logic [FIELD_PR_W-1:0]    limit,
    input  logic                     first,
    output cmp_res_t                 res
);

    logic [CMP_W-1:0] data_ext;
    logic [CMP_W-1:0] eff_bound;

    always_comb begin
        data_ext  = CMP_W'(data_prio);
        // a zero limit means the oldest entry sets the bound
        eff_bound = (first && (limit == '0)) ? data_ext : bound;
        res.le    = (data_ext <= eff_bound);
        res.bound = res.le ? data_ext : eff_bound;
    end

endmodule

// ----- hdl/priority_wait_list_select_top.sv -----
// priority wait list select: insert at tail, extract lowest priority within a bound
// sequence: an insert goes from accept to ST_RESULT, then to the registered m_axis_tvalid; an
// extract scans the held entries in ST_SCAN, shifts the entries past the pick down in ST_COMPACT
// (skipped if none is found), then ST_RESULT; throughput: one item at a time, s_axis_tready high
// only while idle; the single compare unit and the single list memory read port set the per-entry pace
// reset: aresetn (sync, active low) empties the list; stored entries are not cleared
`timescale 1ns / 1ps

module priority_wait_list_select_top
    import pwls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] entry_tag, [15:8] entry_priority, [23:16] priority_limit
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] found, [8:1] out_tag, [16:9] out_priority, [17] list_full, [22:18] occupancy
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CMP_W-1:0]      bound_reg, bound_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [TAG_W-1:0]      res_tag_reg, res_tag_next;
    logic [FIELD_PR_W-1:0] res_prio_reg, res_prio_next;
    logic                  found_reg, found_next;
    logic                  full_reg, full_next;
    logic [FIELD_PR_W-1:0] limit_reg, limit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  s_acc;
    logic                  in_mode;
    logic [TAG_W-1:0]      in_tag;
    logic [FIELD_PR_W-1:0] in_prio;
    logic [FIELD_PR_W-1:0] in_limit;
    logic                  list_is_full;
    logic                  issue_more;
    logic                  scan_last;
    logic                  hit_now;
    logic [IDX_W-1:0]      pick_now;
    logic                  out_free;
    logic [CMP_W-1:0]      in_prio_ext;
    logic [CMP_W-1:0]      rd_prio_ext;
    logic [OCC_EXT_W-1:0]  occ_ext;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;
    entry_t                mem_rdata;
    cmp_res_t              cmp_res;

    assign in_mode  = s_axis_tuser[0];
    assign in_tag   = s_axis_tdata[7:0];
    assign in_prio  = s_axis_tdata[15:8];
    assign in_limit = s_axis_tdata[23:16];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign list_is_full = (cnt_reg == CNT_W'(LIST_DEPTH));
    assign issue_more   = (iss_reg < cnt_reg);
    assign scan_last    = rd_vld_reg && ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg);
    assign hit_now      = hit_reg || (rd_vld_reg && cmp_res.le);
    assign pick_now     = (rd_vld_reg && cmp_res.le) ? rd_idx_reg : pick_reg;
    assign out_free     = !m_valid_reg || m_axis_tready;
    assign in_prio_ext  = CMP_W'(in_prio);
    assign rd_prio_ext  = CMP_W'(mem_rdata.prio);
    assign occ_ext      = OCC_EXT_W'(cnt_reg);

    pwls_list_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    pwls_cmp_unit u_cmp (
        .data_prio (mem_rdata.prio),
        .bound     (bound_reg),
        .limit     (limit_reg),
        .first     (rd_idx_reg == '0),
        .res       (cmp_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_mode == MODE_INSERT || cnt_reg == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = hit_now ? ST_COMPACT : ST_RESULT;
                end
            end
            ST_COMPACT: begin
                if (!issue_more && !rd_vld_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        bound_next    = bound_reg;
        hit_next      = hit_reg;
        pick_next     = pick_reg;
        res_tag_next  = res_tag_reg;
        res_prio_next = res_prio_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        limit_next    = limit_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg[IDX_W-1:0];
        mem_wdata.tag  = in_tag;
        mem_wdata.prio = in_prio_ext[PRIORITY_BITS-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    limit_next    = in_limit;
                    bound_next    = CMP_W'(in_limit);
                    iss_next      = '0;
                    hit_next      = 1'b0;
                    pick_next     = '0;
                    res_tag_next  = '0;
                    res_prio_next = '0;
                    found_next    = 1'b0;
                    full_next     = 1'b0;
                    if (in_mode == MODE_INSERT) begin
                        if (list_is_full) begin
                            full_next = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            found_next = 1'b1;
                            cnt_next   = cnt_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (issue_more) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IDX_W-1:0];
                    iss_next    = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    bound_next = cmp_res.bound;
                    if (cmp_res.le) begin
                        hit_next      = 1'b1;
                        pick_next     = rd_idx_reg;
                        res_tag_next  = mem_rdata.tag;
                        res_prio_next = rd_prio_ext[FIELD_PR_W-1:0];
                    end
                end
                if (scan_last && hit_now) begin
                    found_next = 1'b1;
                    // compaction starts reading just past the chosen entry
                    iss_next   = CNT_W'(pick_now) + CNT_W'(1);
                end
            end
            ST_COMPACT: begin
                if (issue_more) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IDX_W-1:0];
                    iss_next    = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg - IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (!issue_more && !rd_vld_reg) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_DATA_W - OUT_USED_W)'(0), occ_ext[OCC_W-1:0],
                                    full_reg, res_prio_reg, res_tag_reg, found_reg};
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg      <= iss_next;
        rd_idx_reg   <= rd_idx_next;
        bound_reg    <= bound_next;
        hit_reg      <= hit_next;
        pick_reg     <= pick_next;
        res_tag_reg  <= res_tag_next;
        res_prio_reg <= res_prio_next;
        found_reg    <= found_next;
        full_reg     <= full_next;
        limit_reg    <= limit_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ----- hdl/pwls_checker.sv -----
// port-level checks for the priority wait list select block, bound to the top level
// depends on pwls_pkg and priority_wait_list_select_top
`timescale 1ns / 1ps

module pwls_checker
    import pwls_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // one item in flight: no new beat straight after an accepted one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is still in work");

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed before it was taken");

    // a refused insert carries no entry
    a_full_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[17]) |-> (!m_axis_tdata[0] && m_axis_tdata[16:1] == '0))
        else $error("refused insert reports an entry");

    // occupancy never above the list size
    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (int'(m_axis_tdata[22:18]) <= LIST_DEPTH))
        else $error("occupancy beyond list depth");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

endmodule

bind priority_wait_list_select_top pwls_checker u_pwls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
